@@ rtl/vfbp_pkg.sv @@
// Shared types and constants for the value fingerprint branch predictor.
package vfbp_pkg;

  // Fixed field widths.
  localparam int unsigned AddrW   = 64;
  localparam int unsigned SrcW    = 64;
  localparam int unsigned TagW    = 8;
  localparam int unsigned AgeW    = 2;
  localparam int unsigned DigitW  = 16;
  localparam int unsigned ModCntW = 3;

  localparam logic [TagW-1:0]    FpMask   = 8'hFF;
  localparam logic [AgeW-1:0]    AgeMax   = 2'd3;
  // Last remainder step; each 16-bit digit of the 64-bit address takes a multiply and a subtract step.
  localparam logic [ModCntW-1:0] ModLastC = 3'd7;

  // Request operation codes.
  typedef enum logic {
    OP_PREDICT = 1'b0,
    OP_UPDATE  = 1'b1
  } op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_EVAL
  } state_e;

  // One way of a set as held in the table memory.
  typedef struct packed {
    logic            valid;
    logic [TagW-1:0] tag;
    logic            outcome;
    logic [AgeW-1:0] age;
  } way_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clr_en;
    logic mod_step;
    logic rd_en;
    logic eval;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic pow2;
  } ctrl_sts_t;

endpackage

@@ rtl/vfbp_ram.sv @@
// Generic RAM with one write port and one registered read port.
module vfbp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/vfbp_ctrl.sv @@
// Controller state machine for the predictor.
module vfbp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  vfbp_pkg::ctrl_sts_t sts_i,
  output vfbp_pkg::ctrl_cmd_t cmd_o
);
  import vfbp_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = sts_i.pow2 ? ST_READ : ST_MOD;
      end
      ST_MOD: begin
        if (sts_i.mod_last) state_d = ST_READ;
      end
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      ST_CLEAR: cmd_o.clr_en = 1'b1;
      ST_IDLE: begin
        busy          = 1'b0;
        cmd_o.capture = start;
      end
      ST_MOD:  cmd_o.mod_step = 1'b1;
      ST_READ: cmd_o.rd_en = 1'b1;
      ST_EVAL: cmd_o.eval = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

@@ rtl/vfbp_datapath.sv @@
// Datapath: set index reduction, table memory, lookup and replacement.
module vfbp_datapath #(
  parameter int unsigned SETS = 1024,
  parameter int unsigned WAYS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vfbp_pkg::ctrl_cmd_t           cmd_i,
  output vfbp_pkg::ctrl_sts_t           sts_o,
  input  logic                          operation_i,
  input  logic [vfbp_pkg::AddrW-1:0]    branch_address_i,
  input  logic [vfbp_pkg::SrcW-1:0]     first_source_i,
  input  logic [vfbp_pkg::SrcW-1:0]     second_source_i,
  input  logic                          taken_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic                          predicted_taken_o
);
  import vfbp_pkg::*;

  localparam int unsigned SetW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned RowW    = WAYS * $bits(way_t);
  localparam bit          Pow2    = ((SETS & (SETS - 1)) == 0);
  localparam logic [SetW-1:0] SetMask = SetW'(SETS - 1);

  // Reciprocal of SETS for a 32-bit partial remainder v:
  // floor(v / SETS) equals (v * Recip) >> RecK for every v below 2**32.
  localparam int unsigned     RemW    = 2 * DigitW;
  localparam int unsigned     RecK    = RemW + SetW;
  localparam longint unsigned RecipL  = ((64'd1 << RecK) + 64'(SETS) - 64'd1) / 64'(SETS);
  localparam logic [RemW:0]   Recip   = (RemW + 1)'(RecipL);
  localparam logic [RemW-1:0] SetsRem = RemW'(SETS);

  // Captured request.
  op_e               op_q;
  logic [TagW-1:0]   fp_q;
  logic              taken_q;
  logic [AddrW-1:0]  addr_sh_q;
  logic [SetW-1:0]   set_q;
  logic [ModCntW-1:0] mod_cnt_q;
  logic [SetW-1:0]   clr_idx_q;

  // Result registers.
  logic done_q, hit_q, pred_q;

  // Memory ports.
  logic             ram_we;
  logic [SetW-1:0]  ram_waddr;
  logic [RowW-1:0]  ram_wdata;
  logic [RowW-1:0]  ram_rdata;

  // Lookup signals.
  way_t [WAYS-1:0]  row_rd;
  way_t [WAYS-1:0]  row_wr;
  logic [WAYS-1:0]  match, match_first, inval, inval_first;
  logic [WAYS-1:0]  age_sel, age_first, victim, target;
  logic [WAYS-1:0]  age_hi, age_lo_both, age_lo;
  logic [AgeW-1:0]  age_top;
  logic             hit, pred;

  // Remainder step, one 16-bit address digit at a time, most significant first.
  logic [2*RemW:0]  prod_q;
  logic [RemW-1:0]  rem_v;
  logic [RemW-1:0]  quot;
  logic [RemW-1:0]  quot_s;
  logic [RemW-1:0]  rem_next;

  // The partial remainder is below SETS, so it fits one digit and v stays under 2**32.
  assign rem_v    = {DigitW'(set_q), addr_sh_q[AddrW-1 -: DigitW]};
  assign quot     = RemW'(prod_q >> RecK);
  // The product never exceeds v, so 32 bits hold it.
  assign quot_s   = quot * SetsRem;
  assign rem_next = rem_v - quot_s;

  // Request capture and set index computation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_e'(operation_i);
      fp_q      <= first_source_i[TagW-1:0] ^ second_source_i[TagW-1:0] & FpMask;
      taken_q   <= taken_i;
      addr_sh_q <= branch_address_i;
      set_q     <= Pow2 ? (branch_address_i[SetW-1:0] & SetMask) : '0;
    end else if (cmd_i.mod_step) begin
      if (!mod_cnt_q[0]) begin
        prod_q <= rem_v * Recip;
      end else begin
        addr_sh_q <= {addr_sh_q[AddrW-DigitW-1:0], {DigitW{1'b0}}};
        set_q     <= rem_next[SetW-1:0];
      end
    end
  end

  // Iteration counter for the remainder steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_cnt_q <= '0;
    end else if (cmd_i.capture) begin
      mod_cnt_q <= '0;
    end else if (cmd_i.mod_step) begin
      mod_cnt_q <= mod_cnt_q + 1'b1;
    end
  end

  // Row counter for the clearing pass after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  assign sts_o.clr_last = (clr_idx_q == SetW'(SETS - 1));
  assign sts_o.mod_last = (mod_cnt_q == ModLastC);
  assign sts_o.pow2     = Pow2;

  // Table memory, one row per set.
  assign ram_we    = cmd_i.clr_en || (cmd_i.eval && (op_q == OP_UPDATE));
  assign ram_waddr = cmd_i.clr_en ? clr_idx_q : set_q;
  assign ram_wdata = cmd_i.clr_en ? '0 : RowW'(row_wr);

  vfbp_ram #(
    .Width (RowW),
    .Depth (SETS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (set_q),
    .rdata_o (ram_rdata)
  );

  assign row_rd = ram_rdata;

  // Per-way compare and age decode.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w]       = row_rd[w].valid && (row_rd[w].tag == fp_q);
      inval[w]       = !row_rd[w].valid;
      age_hi[w]      = row_rd[w].age[1];
      age_lo_both[w] = row_rd[w].age[1] & row_rd[w].age[0];
      age_lo[w]      = row_rd[w].age[0];
    end
  end

  // Greatest age in the set, found bit by bit.
  assign age_top[1] = |age_hi;
  assign age_top[0] = age_top[1] ? |age_lo_both : |age_lo;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      age_sel[w] = (row_rd[w].age == age_top);
    end
  end

  // Lowest-index picks.
  assign match_first = match & (~match + 1'b1);
  assign inval_first = inval & (~inval + 1'b1);
  assign age_first   = age_sel & (~age_sel + 1'b1);

  assign hit    = |match;
  assign victim = (|inval) ? inval_first : age_first;
  assign target = hit ? match_first : victim;

  always_comb begin
    pred = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      pred = pred | (match_first[w] & row_rd[w].outcome);
    end
  end

  // Updated row: the target way is refreshed, the other valid ways age.
  always_comb begin
    row_wr = row_rd;
    for (int w = 0; w < WAYS; w++) begin
      if (target[w]) begin
        row_wr[w].valid   = 1'b1;
        row_wr[w].tag     = fp_q;
        row_wr[w].outcome = taken_q;
        row_wr[w].age     = '0;
      end else if (row_rd[w].valid && (row_rd[w].age != AgeMax)) begin
        row_wr[w].age = row_rd[w].age + 1'b1;
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.eval;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      hit_q  <= hit;
      pred_q <= hit & pred;
    end
  end

  assign done_o            = done_q;
  assign hit_o             = hit_q;
  assign predicted_taken_o = pred_q;

endmodule

@@ rtl/value_fingerprint_branch_predictor.sv @@
// Top level of the value fingerprint branch outcome predictor.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+--------------------------------------------
//  request  | start / busy           | operation_i, branch_address_i,
//           |                        | first_source_i, second_source_i, taken_i
//  result   | done_o (one-cycle)     | hit_o, predicted_taken_o
//
// The result strobe is registered in the EVAL state, which follows READ when SETS is a power of
// two; otherwise MOD states first reduce the set index one 16-bit address digit at a time. The
// next request can be taken at the edge that takes the result. The table memory is read once
// per request and written once per update request.
// After reset a clearing pass writes every set, with busy held high.
// The result is shown for one cycle only; the receiver cannot stall it.
module value_fingerprint_branch_predictor #(
  parameter int unsigned SETS = 1024,
  parameter int unsigned WAYS = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       operation_i,
  input  logic [vfbp_pkg::AddrW-1:0] branch_address_i,
  input  logic [vfbp_pkg::SrcW-1:0]  first_source_i,
  input  logic [vfbp_pkg::SrcW-1:0]  second_source_i,
  input  logic                       taken_i,
  output logic                       done_o,
  output logic                       hit_o,
  output logic                       predicted_taken_o
);
  import vfbp_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer.
  vfbp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Table and lookup logic.
  vfbp_datapath #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .operation_i       (operation_i),
    .branch_address_i  (branch_address_i),
    .first_source_i    (first_source_i),
    .second_source_i   (second_source_i),
    .taken_i           (taken_i),
    .done_o            (done_o),
    .hit_o             (hit_o),
    .predicted_taken_o (predicted_taken_o)
  );

  // An accepted request keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a request");

  // Results never come in two consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // A result follows the evaluation cycle of a busy block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.eval |=> done_o)
    else $error("evaluation did not produce a result");

  // The clearing pass and a request are never in progress together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_en |-> (busy && !cmd.capture && !cmd.eval))
    else $error("request activity during the clearing pass");

endmodule

@@ tb/tb_value_fingerprint_branch_predictor.sv @@
// Self-checking testbench for the value fingerprint branch predictor, with a set table scoreboard.
`timescale 1ns / 1ps

module tb_value_fingerprint_branch_predictor;
  import vfbp_pkg::*;

  localparam int unsigned SETS        = 1024;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned RAND_ITEMS  = 1700;
  localparam int unsigned QUIET_ITEMS = 300;
  localparam int unsigned DRAIN_CYC   = 80;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // One predicted response of the block.
  typedef struct packed {
    logic hit;
    logic pred_taken;
  } prediction_t;

  // Shadow copy of the outcome table; it predicts each response and checks the block.
  class outcome_table;
    bit              vld  [SETS*WAYS];
    bit [TagW-1:0]   tag  [SETS*WAYS];
    bit              outc [SETS*WAYS];
    bit [AgeW-1:0]   age  [SETS*WAYS];
    prediction_t     pending_predictions[$];
    int unsigned     errors;

    // Looks up the fingerprint, queues the response and trains the table on an update.
    function void note_request(op_e op, logic [AddrW-1:0] addr, logic [SrcW-1:0] src1,
                               logic [SrcW-1:0] src2, logic tk);
      int unsigned     base;
      int unsigned     slot;
      bit              found;
      bit              free_found;
      logic [TagW-1:0] fp;
      prediction_t     resp;
      base  = int'(addr % SETS) * WAYS;
      fp    = (src1[TagW-1:0] ^ src2[TagW-1:0]) & FpMask;
      found = 1'b0;
      slot  = 0;
      for (int unsigned w = 0; w < WAYS; w++) begin
        if (!found && vld[base+w] && tag[base+w] == fp) begin
          found = 1'b1;
          slot  = w;
        end
      end
      resp.hit        = found;
      resp.pred_taken = found ? outc[base+slot] : 1'b0;
      pending_predictions = {pending_predictions, resp};
      if (op == OP_PREDICT) return;

      // On a miss pick the first free way, else the lowest way of greatest age.
      if (!found) begin
        free_found = 1'b0;
        for (int unsigned w = 0; w < WAYS; w++) begin
          if (!free_found && !vld[base+w]) begin
            free_found = 1'b1;
            slot       = w;
          end
        end
        if (!free_found) begin
          slot = 0;
          for (int unsigned w = 1; w < WAYS; w++) begin
            if (age[base+w] > age[base+slot]) slot = w;
          end
        end
      end

      // The touched way becomes youngest; every other valid way ages, saturating.
      vld[base+slot]  = 1'b1;
      tag[base+slot]  = fp;
      outc[base+slot] = tk;
      age[base+slot]  = '0;
      for (int unsigned w = 0; w < WAYS; w++) begin
        if (w != slot && vld[base+w] && age[base+w] < AgeMax) age[base+w] = age[base+w] + 1'b1;
      end
    endfunction

    // Compares one response strobe with the oldest prediction.
    function void check_result(logic hit, logic pred_taken);
      prediction_t want;
      if (pending_predictions.size() == 0) begin
        $display("%0t: unexpected response hit=%b predicted_taken=%b", $time, hit, pred_taken);
        errors++;
        return;
      end
      want = pending_predictions.pop_front();
      if (hit !== want.hit) begin
        $display("%0t: hit mismatch expected %b actual %b", $time, want.hit, hit);
        errors++;
      end
      if (pred_taken !== want.pred_taken) begin
        $display("%0t: predicted_taken mismatch expected %b actual %b",
                 $time, want.pred_taken, pred_taken);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             operation_i;
  logic [AddrW-1:0] branch_address_i;
  logic [SrcW-1:0]  first_source_i;
  logic [SrcW-1:0]  second_source_i;
  logic             taken_i;
  logic             done_o;
  logic             hit_o;
  logic             predicted_taken_o;

  outcome_table sb;
  int unsigned cycles;

  value_fingerprint_branch_predictor #(
    .SETS(SETS),
    .WAYS(WAYS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .branch_address_i (branch_address_i),
    .first_source_i   (first_source_i),
    .second_source_i  (second_source_i),
    .taken_i          (taken_i),
    .done_o           (done_o),
    .hit_o            (hit_o),
    .predicted_taken_o(predicted_taken_o)
  );

  // Free-running clock.
  always #5 clk_i = ~clk_i;

  // Response monitor; the strobe lasts one cycle and cannot be held off.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) sb.check_result(hit_o, predicted_taken_o);
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random address whose set index is the given one; the upper bits alias freely.
  function automatic logic [AddrW-1:0] addr_in_set(int unsigned set_idx);
    logic [AddrW-1:0] a;
    a = rand64();
    return a - (a % SETS) + set_idx;
  endfunction

  // Second operand that gives the wanted fingerprint against the first one.
  function automatic logic [SrcW-1:0] src_with_fp(logic [SrcW-1:0] src1, logic [TagW-1:0] fp);
    logic [SrcW-1:0] s;
    s = rand64();
    s[TagW-1:0] = src1[TagW-1:0] ^ fp;
    return s;
  endfunction

  // Presents one request and holds it until the block takes it; start stays high afterwards.
  task automatic send_request(op_e op, logic [AddrW-1:0] addr, logic [SrcW-1:0] src1,
                              logic [SrcW-1:0] src2, logic tk);
    start            <= 1'b1;
    operation_i      <= op;
    branch_address_i <= addr;
    first_source_i   <= src1;
    second_source_i  <= src2;
    taken_i          <= tk;
    forever begin
      @(posedge clk_i);
      if (busy === 1'b0) break;
    end
    sb.note_request(op, addr, src1, src2, tk);
  endtask

  // Sends an item to the given set with the given fingerprint and random other bits.
  task automatic send_branch(op_e op, int unsigned set_idx, logic [TagW-1:0] fp, logic tk);
    logic [SrcW-1:0] s1;
    s1 = rand64();
    send_request(op, addr_in_set(set_idx), s1, src_with_fp(s1, fp), tk);
  endtask

  initial begin
    int unsigned     hot_sets [6];
    logic [TagW-1:0] fp_pool  [6];
    int unsigned     set_idx;
    logic [TagW-1:0] fp;
    op_e             op;

    sb               = new();
    rst_ni           <= 1'b0;
    start            <= 1'b0;
    operation_i      <= OP_PREDICT;
    branch_address_i <= '0;
    first_source_i   <= '0;
    second_source_i  <= '0;
    taken_i          <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table, zero and all-ones operands, aliasing upper address bits.
    send_request(OP_PREDICT, '0, '0, '0, 1'b1);
    send_request(OP_UPDATE, '0, '0, '0, 1'b1);
    send_request(OP_PREDICT, 64'(SETS), '1, '1, 1'b0);
    send_request(OP_UPDATE, '1, '1, '0, 1'b0);
    send_request(OP_PREDICT, '1, '0, '1, 1'b1);

    // Fill a set, hit in it, then keep one way young so the others saturate.
    send_branch(OP_UPDATE, 7, 8'h11, 1'b1);
    send_branch(OP_UPDATE, 7, 8'h22, 1'b0);
    send_branch(OP_UPDATE, 7, 8'h33, 1'b1);
    send_branch(OP_UPDATE, 7, 8'h44, 1'b0);
    send_branch(OP_PREDICT, 7, 8'h22, 1'b1);
    send_branch(OP_UPDATE, 7, 8'h33, 1'b0);
    send_branch(OP_PREDICT, 7, 8'h33, 1'b0);
    repeat (4) send_branch(OP_UPDATE, 7, 8'h11, 1'b1);

    // Full set with an age tie: the lowest-index oldest way is evicted.
    send_branch(OP_UPDATE, 7, 8'h55, 1'b1);
    send_branch(OP_PREDICT, 7, 8'h22, 1'b0);
    send_branch(OP_PREDICT, 7, 8'h55, 1'b0);
    send_branch(OP_UPDATE, 7, 8'h66, 1'b0);
    send_branch(OP_PREDICT, 7, 8'h33, 1'b1);
    send_branch(OP_PREDICT, 7, 8'h66, 1'b1);
    send_branch(OP_PREDICT, 7, 8'h11, 1'b0);

    // A few hot sets and fingerprints so that sets fill, age and evict often.
    hot_sets[0] = 0;
    hot_sets[1] = SETS - 1;
    for (int i = 2; i < 6; i++) hot_sets[i] = $urandom_range(0, SETS - 1);
    for (int i = 0; i < 6; i++) fp_pool[i] = 8'($urandom);

    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      if (i < RAND_ITEMS - QUIET_ITEMS && $urandom_range(0, 7) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      set_idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SETS - 1)
                                            : hot_sets[$urandom_range(0, 5)];
      fp      = ($urandom_range(0, 9) == 0) ? 8'($urandom) : fp_pool[$urandom_range(0, 5)];
      op      = ($urandom_range(0, 9) < 6) ? OP_UPDATE : OP_PREDICT;
      send_branch(op, set_idx, fp, 1'($urandom));
    end
    start <= 1'b0;

    // Drain outstanding responses, then watch for stray strobes.
    while (sb.pending_predictions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/vfbp_pkg.sv
rtl/vfbp_ram.sv
rtl/vfbp_ctrl.sv
rtl/vfbp_datapath.sv
rtl/value_fingerprint_branch_predictor.sv
tb/tb_value_fingerprint_branch_predictor.sv
